/* hw/rtl/tse_pkg.sv */
`timescale 1ns / 1ps
package tse_pkg;

  // default size of the bus-read byte array
  localparam int TSE_ARRAY_BYTES = 16;

  // instruction codes
  localparam logic [3:0] CMD_BEGIN      = 4'd0;
  localparam logic [3:0] CMD_LOAD       = 4'd1;
  localparam logic [3:0] CMD_CMP        = 4'd2;
  localparam logic [3:0] CMD_CMP_ANY    = 4'd3;
  localparam logic [3:0] CMD_RET_FALSE  = 4'd4;
  localparam logic [3:0] CMD_RET_TRUE   = 4'd5;
  localparam logic [3:0] CMD_MOVE_BYTE  = 4'd6;
  localparam logic [3:0] CMD_MOVE       = 4'd7;
  localparam logic [3:0] CMD_AND        = 4'd8;
  localparam logic [3:0] CMD_SCALE      = 4'd9;
  localparam logic [3:0] CMD_LIMIT      = 4'd10;
  localparam logic [3:0] CMD_RET        = 4'd11;
  localparam logic [3:0] CMD_END        = 4'd12;
  localparam logic [3:0] CMD_CMP_RESULT = 4'd13;

  // move modes
  localparam logic [1:0] MOVE_SINGLE = 2'd1;
  localparam logic [1:0] MOVE_BIG    = 2'd2;

  // end kinds
  localparam logic [1:0] END_RETURN = 2'd0;
  localparam logic [1:0] END_EARLY  = 2'd1;
  localparam logic [1:0] END_PROG   = 2'd2;

  // move result mask
  localparam logic [15:0] MOVE_MASK = 16'h0fff;

  // saturation bounds of the scale result
  localparam logic signed [31:0] SAT_MAX = 32'sd32767;
  localparam logic signed [31:0] SAT_MIN = -32'sd32768;

  typedef struct packed {
    logic [3:0]         cmd;
    logic [3:0]         array_index;
    logic [7:0]         byte_value;
    logic               first_value;
    logic               half_select;
    logic [1:0]         move_mode;
    logic [15:0]        word_value;
    logic signed [31:0] scale_factor;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] value;
    logic [1:0]         end_kind;
  } out_item_t;

  // execute unit outcome
  typedef struct packed {
    logic [15:0] work_nxt;
    logic        halted_nxt;
    logic        emit;
    out_item_t   res;
  } alu_res_t;

endpackage

/* hw/rtl/touch_script_executor.sv */
`timescale 1ns / 1ps
// Channel   Direction  Handshake           Beat
// in_       input      in_valid/in_stall   one decoded instruction (in_item_t)
// out_      output     out_valid/out_stall one script result (out_item_t)
//
// One instruction per cycle sustained while the output is not stalled.
// Stage one registers the beat and reads the byte array; stage two executes against
// the working result and loads the output register.
// Reset clears working result, halted flag and all array entries (valid bits).
// A stalled output holds the execute stage, which in turn stalls the input.
module touch_script_executor #(
  parameter int ARRAY_BYTES = tse_pkg::TSE_ARRAY_BYTES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tse_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tse_pkg::out_item_t  out_data
);
  import tse_pkg::*;

  localparam int IDX_W = $clog2(ARRAY_BYTES);

  logic [IDX_W-1:0] mod_tab [16];

  in_item_t         ex_item_r;
  logic             ex_valid_r;
  logic             ex_fire;
  logic             in_fire;
  logic [IDX_W-1:0] rd_a;
  logic [IDX_W-1:0] rd_b;
  logic [IDX_W-1:0] wr_addr;
  logic             wr_en;
  logic [7:0]       ram_qa;
  logic [7:0]       ram_qb;
  logic             fwd_a_r;
  logic             fwd_b_r;
  logic [7:0]       fwd_d_r;
  logic             ok_a_r;
  logic             ok_b_r;
  logic [7:0]       byte_a;
  logic [7:0]       byte_b;
  logic [7:0]       byte0_r;
  logic [ARRAY_BYTES-1:0] valid_r;
  logic [15:0]      work_r;
  logic             halted_r;
  logic             out_valid_r;
  out_item_t        out_item_r;
  alu_res_t         alu_res;

  // index modulo array size, worked out per code at elaboration
  for (genvar k = 0; k < 16; k++) begin : g_mod
    assign mod_tab[k] = IDX_W'(k % ARRAY_BYTES);
  end

  // handshake
  assign ex_fire  = ex_valid_r && !(out_valid_r && out_stall);
  assign in_stall = ex_valid_r && !ex_fire;
  assign in_fire  = in_valid && !in_stall;

  // read addresses for the arriving beat
  assign rd_a = mod_tab[in_data.array_index];
  assign rd_b = (rd_a == IDX_W'(ARRAY_BYTES - 1)) ? '0 : rd_a + IDX_W'(1);

  // array write from the executing load
  assign wr_addr = mod_tab[ex_item_r.array_index];
  assign wr_en   = ex_fire && !halted_r && (ex_item_r.cmd == CMD_LOAD);

  tse_ram #(
    .WIDTH (8),
    .DEPTH (ARRAY_BYTES)
  ) u_ram (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (wr_addr),
    .wdata   (ex_item_r.byte_value),
    .re      (in_fire),
    .raddr_a (rd_a),
    .raddr_b (rd_b),
    .rdata_a (ram_qa),
    .rdata_b (ram_qb)
  );

  // input register plus read bypass of a load landing in the same cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_valid_r <= 1'b0;
    end else if (in_fire) begin
      ex_valid_r <= 1'b1;
    end else if (ex_fire) begin
      ex_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ex_item_r <= in_data;
      fwd_a_r   <= wr_en && (wr_addr == rd_a);
      fwd_b_r   <= wr_en && (wr_addr == rd_b);
      fwd_d_r   <= ex_item_r.byte_value;
      ok_a_r    <= valid_r[rd_a];
      ok_b_r    <= valid_r[rd_b];
    end
  end

  // entries never written read as zero
  assign byte_a = fwd_a_r ? fwd_d_r : (ok_a_r ? ram_qa : 8'h00);
  assign byte_b = fwd_b_r ? fwd_d_r : (ok_b_r ? ram_qb : 8'h00);

  tse_alu u_alu (
    .item     (ex_item_r),
    .work_r   (work_r),
    .halted_r (halted_r),
    .byte0    (byte0_r),
    .byte_a   (byte_a),
    .byte_b   (byte_b),
    .res      (alu_res)
  );

  // script state and array bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_r   <= '0;
      halted_r <= 1'b0;
      byte0_r  <= '0;
      valid_r  <= '0;
    end else begin
      if (ex_fire) begin
        work_r   <= alu_res.work_nxt;
        halted_r <= alu_res.halted_nxt;
      end
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
        if (wr_addr == '0) begin
          byte0_r <= ex_item_r.byte_value;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ex_fire && alu_res.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_fire && alu_res.emit) begin
      out_item_r <= alu_res.res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // checks
  a_emit_halts: assert property (@(posedge clk) disable iff (!rst_n)
    ex_fire && alu_res.emit |=> halted_r)
    else $error("result emitted without halting");

  a_halt_holds: assert property (@(posedge clk) disable iff (!rst_n)
    ex_fire && halted_r && (ex_item_r.cmd != CMD_BEGIN) |=> $stable(work_r) && halted_r)
    else $error("halted script changed state");

  a_begin_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ex_fire && (ex_item_r.cmd == CMD_BEGIN) |=> (work_r == 16'd0) && !halted_r)
    else $error("begin did not clear state");

  a_write_marks: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> valid_r[$past(wr_addr)])
    else $error("written entry not marked valid");

  a_stall_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !ex_valid_r |-> !in_stall)
    else $error("input stalled with empty execute stage");

endmodule

/* hw/rtl/tse_ram.sv */
`timescale 1ns / 1ps
module tse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // one write port, two registered read ports (read-old on collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem_r[raddr_a];
      rdata_b <= mem_r[raddr_b];
    end
  end

endmodule

/* hw/rtl/tse_alu.sv */
`timescale 1ns / 1ps
module tse_alu (
  input  tse_pkg::in_item_t item,
  input  logic [15:0]       work_r,
  input  logic              halted_r,
  input  logic [7:0]        byte0,
  input  logic [7:0]        byte_a,
  input  logic [7:0]        byte_b,
  output tse_pkg::alu_res_t res
);
  import tse_pkg::*;

  logic               hit0;
  logic [15:0]        move_word;
  logic signed [15:0] diff_s;
  logic signed [47:0] prod_s;
  logic signed [31:0] quot_s;
  logic [15:0]        scaled;

  // byte-zero match for the CMP and CMP_ANY instructions
  assign hit0 = (item.byte_value == byte0);

  // word assembled from the array for move
  always_comb begin
    case (item.move_mode)
      MOVE_SINGLE: move_word = {8'h00, byte_a};
      MOVE_BIG:    move_word = {byte_a, byte_b};
      default:     move_word = {byte_b, byte_a};
    endcase
  end

  // offset, Q16.16 multiply, truncate toward zero, saturate
  assign diff_s = $signed(work_r - item.word_value);
  assign prod_s = 48'($signed(item.scale_factor)) * 48'(diff_s);
  assign quot_s = prod_s[47:16] + {31'd0, prod_s[47] & (|prod_s[15:0])};

  always_comb begin
    if (quot_s > SAT_MAX) begin
      scaled = SAT_MAX[15:0];
    end else if (quot_s < SAT_MIN) begin
      scaled = SAT_MIN[15:0];
    end else begin
      scaled = quot_s[15:0];
    end
  end

  // instruction decode
  always_comb begin
    res.work_nxt   = work_r;
    res.halted_nxt = halted_r;
    res.emit       = 1'b0;
    res.res.value  = '0;
    res.res.end_kind = END_RETURN;
    if (item.cmd == CMD_BEGIN) begin
      res.work_nxt   = '0;
      res.halted_nxt = 1'b0;
    end else if (!halted_r) begin
      unique case (item.cmd)
        CMD_CMP: res.work_nxt = {15'd0, hit0};
        CMD_CMP_ANY: begin
          res.work_nxt = (item.first_value ? 16'd0 : work_r) | {15'd0, hit0};
        end
        CMD_CMP_RESULT: res.work_nxt = {15'd0, work_r == {8'h00, item.byte_value}};
        CMD_RET_FALSE: begin
          if (work_r == 16'd0) begin
            res.emit = 1'b1;
            res.res.end_kind = END_EARLY;
          end
        end
        CMD_RET_TRUE: begin
          if (!work_r[15] && (work_r != 16'd0)) begin
            res.emit = 1'b1;
            res.res.end_kind = END_EARLY;
          end
        end
        CMD_MOVE_BYTE: begin
          res.work_nxt = item.half_select ? {byte_a, work_r[7:0]}
                                          : {work_r[15:8], byte_a};
        end
        CMD_MOVE:  res.work_nxt = move_word & MOVE_MASK;
        CMD_AND:   res.work_nxt = work_r & item.word_value;
        CMD_SCALE: res.work_nxt = scaled;
        CMD_LIMIT: begin
          if (!work_r[15] && (work_r > item.word_value)) begin
            res.work_nxt = item.word_value;
          end
        end
        CMD_RET: begin
          res.emit = 1'b1;
          res.res.value = work_r;
          res.res.end_kind = END_RETURN;
        end
        CMD_END: begin
          res.emit = 1'b1;
          res.res.value = work_r;
          res.res.end_kind = END_PROG;
        end
        default: ; // load is handled at the array; unused codes do nothing
      endcase
      if (res.emit) begin
        res.halted_nxt = 1'b1;
      end
    end
  end

endmodule
